// File: rtl/ole_pkg.sv
// Package for the ordered list engine: request codes, status codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none
package ole_pkg;

  typedef enum logic [3:0] {
    REQ_INS_FRONT  = 4'd0,
    REQ_INS_END    = 4'd1,
    REQ_INS_BEFORE = 4'd2,
    REQ_INS_AFTER  = 4'd3,
    REQ_DEL_FRONT  = 4'd4,
    REQ_DEL_END    = 4'd5,
    REQ_DEL_VALUE  = 4'd6,
    REQ_SEARCH     = 4'd7,
    REQ_DUMP       = 4'd8
  } req_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY,
    S_RESULT,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic dump_start;
    logic dump_step;
  } cmd_t;

  typedef struct packed {
    logic [3:0] req;
    logic       dump_done;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/ole_ctrl.sv
// Controller state machine of the ordered list engine.
// Depends on ole_pkg; drives the datapath by cmd_t and reads sts_t.
`default_nettype none
module ole_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_fire,
  output logic              in_ready,
  output logic              res_valid,
  input  wire               res_taken,
  output ole_pkg::cmd_t     cmd,
  input  ole_pkg::sts_t     sts
);
  import ole_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_MATCH;
      S_MATCH:  state_nxt = (sts.req == REQ_DUMP) ? S_DUMP : S_APPLY;
      S_APPLY:  state_nxt = S_RESULT;
      S_RESULT: if (res_taken) state_nxt = S_IDLE;
      S_DUMP:   if (res_taken && sts.dump_done) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    res_valid = 1'b0;
    cmd = '0;
    unique case (state_r)
      S_IDLE:   begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      S_MATCH:  cmd.dump_start = (sts.req == REQ_DUMP);
      S_APPLY:  cmd.apply = 1'b1;
      S_RESULT: res_valid = 1'b1;
      S_DUMP:   begin
        res_valid = 1'b1;
        cmd.dump_step = res_taken;
      end
      default:  ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/ole_dp.sv
// Datapath of the ordered list engine: entry cells with parallel compare,
// shift insert/delete and the dump pointer. Depends on ole_pkg.
`default_nettype none
module ole_dp #(
  parameter int DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [3:0]          in_req,
  input  wire  [31:0]         in_item,
  input  wire  [31:0]         in_target,
  input  ole_pkg::cmd_t       cmd,
  output ole_pkg::sts_t       sts,
  output logic [1:0]          res_status,
  output logic [4:0]          res_position,
  output logic [31:0]         res_element,
  output logic                res_last
);
  import ole_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [31:0]   cell_r [DEPTH];
  logic [CW-1:0] count_r;
  logic [3:0]    req_r;
  logic [31:0]   item_r, target_r;
  logic [DEPTH-1:0] hit_r;
  logic [1:0]    status_r;
  logic [4:0]    pos_r;
  logic [CW-1:0] dptr_r;

  logic [31:0] key;
  logic [DEPTH-1:0] hit;
  assign key = (req_r == REQ_INS_BEFORE || req_r == REQ_INS_AFTER) ? target_r : item_r;

  always_comb begin
    for (int i = 0; i < DEPTH; i++)
      hit[i] = (cell_r[i] == key) && (CW'(i) < count_r);
  end

  logic [CW-1:0] idx;
  logic found;
  always_comb begin
    idx = count_r;
    found = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--)
      if (hit_r[i]) begin
        idx = CW'(i);
        found = 1'b1;
      end
  end

  logic full, empty;
  assign full = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  logic          do_ins, do_del;
  logic [CW-1:0] at;
  logic [1:0]    st;
  logic [4:0]    pos;
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    at = '0;
    st = ST_OK;
    pos = '0;
    case (req_r)
      REQ_INS_FRONT, REQ_INS_END: begin
        if (full) st = ST_FULL;
        else begin
          do_ins = 1'b1;
          at = (req_r == REQ_INS_FRONT) ? '0 : count_r;
        end
      end
      REQ_INS_BEFORE, REQ_INS_AFTER: begin
        if (full) st = ST_FULL;
        else if (empty) st = ST_EMPTY;
        else if (!found) st = ST_NOTFOUND;
        else begin
          do_ins = 1'b1;
          at = (req_r == REQ_INS_BEFORE) ? idx : idx + 1'b1;
        end
      end
      REQ_DEL_FRONT, REQ_DEL_END: begin
        if (empty) st = ST_EMPTY;
        else begin
          do_del = 1'b1;
          at = (req_r == REQ_DEL_FRONT) ? '0 : count_r - 1'b1;
        end
      end
      REQ_DEL_VALUE: begin
        if (empty) st = ST_EMPTY;
        else if (!found) st = ST_NOTFOUND;
        else begin
          do_del = 1'b1;
          at = idx;
        end
      end
      REQ_SEARCH: begin
        if (!found) st = ST_NOTFOUND;
        else pos = 5'(idx + 1'b1);
      end
      REQ_DUMP: if (empty) st = ST_EMPTY;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      if (do_ins) count_r <= count_r + 1'b1;
      else if (do_del) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_ins) begin
          if (CW'(i) == at) cell_r[i] <= item_r;
          else if (CW'(i) > at && i > 0) cell_r[i] <= cell_r[(i > 0) ? i - 1 : 0];
        end else if (do_del) begin
          if (CW'(i) >= at && i < DEPTH - 1) cell_r[i] <= cell_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
      item_r <= in_item;
      target_r <= in_target;
    end
    hit_r <= hit;
    if (cmd.apply || cmd.dump_start) begin
      status_r <= st;
      pos_r <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump_start) dptr_r <= '0;
    else if (cmd.dump_step) dptr_r <= dptr_r + 1'b1;
  end

  logic dump_mode;
  assign dump_mode = (req_r == REQ_DUMP) && !empty;
  assign sts.req = req_r;
  assign sts.dump_done = !dump_mode || (dptr_r + 1'b1 >= count_r);

  assign res_status = dump_mode ? ST_OK : status_r;
  assign res_position = dump_mode ? 5'd0 : pos_r;
  assign res_element = dump_mode ? cell_r[dptr_r[IW-1:0]] : 32'd0;
  assign res_last = sts.dump_done;

endmodule
`default_nettype wire

// File: rtl/ordered_list_engine_top.sv
// Top level of the ordered list engine: ole_ctrl joined to ole_dp.
// Depends on ole_pkg, ole_ctrl and ole_dp.
//
// Usage: requests enter on the in_ stream (tdata holds req_type, item_value,
// target_value from bit 0 up). Results leave on the out_ stream.
// One request is worked at a time. After the accepting edge the match state
// runs the parallel compare over all cells and, for a request other than a
// dump, the apply state then applies the shift, after which its result is
// offered. A dump goes from the match state to offering its first entry and
// then one entry per cycle while the receiver takes them; any other request
// gives one result, with tlast on the final one. The next request is
// accepted in the cycle after the final result has been taken. When the
// receiver stalls, the result holds steady on out_ and the block waits.
// Reset empties the list and returns to the idle state ready for a request.
`default_nettype none
module ordered_list_engine_top #(
  parameter int DEPTH = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: req_type[3:0], item_value[35:4], target_value[67:36].
  input  wire  [71:0]  in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // Fields from bit 0: status[1:0], position[6:2], element[38:7].
  output logic [39:0]  out_tdata,
  output logic         out_tlast
);
  import ole_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic res_valid, in_fire, res_taken;
  logic [1:0] r_status;
  logic [4:0] r_pos;
  logic [31:0] r_elem;
  logic r_last;

  assign in_fire = in_tvalid && in_tready;
  assign res_taken = res_valid && out_tready;

  ole_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_ready(in_tready), .res_valid,
    .res_taken, .cmd, .sts
  );

  ole_dp #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst_n,
    .in_req(in_tdata[3:0]), .in_item(in_tdata[35:4]), .in_target(in_tdata[67:36]),
    .cmd, .sts,
    .res_status(r_status), .res_position(r_pos), .res_element(r_elem), .res_last(r_last)
  );

  assign out_tvalid = res_valid;
  assign out_tdata = {1'b0, r_elem, r_pos, r_status};
  assign out_tlast = r_last;

  logic unused_in;
  assign unused_in = ^in_tdata[71:68];

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("second accept");

endmodule
`default_nettype wire

// File: tb/ole_checker.sv
// Checker for the ordered list engine: watches both streams, keeps its own
// copy of the list, predicts every result and compares. Depends on ole_pkg.
`timescale 1ns / 1ps
module ole_checker #(
  parameter int DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [71:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [39:0] out_tdata,
  input  wire         out_tlast,
  output int          fail_count,
  output int          pending
);
  import ole_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  position;
    logic [31:0] element;
    logic        last;
  } result_t;

  logic [31:0] list_mem [DEPTH];
  int          list_len;
  result_t     result_q [$];

  assign pending = result_q.size();

  function automatic int find_first(logic [31:0] v);
    for (int i = 0; i < list_len; i++) begin
      if (list_mem[i] == v) return i;
    end
    return list_len;
  endfunction

  task automatic put_at(int at, logic [31:0] v);
    for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
    list_mem[at] = v;
    list_len++;
  endtask

  task automatic take_at(int at);
    for (int i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
  endtask

  task automatic predict_request(logic [71:0] d);
    logic [3:0]  req;
    logic [31:0] val;
    logic [31:0] tgt;
    logic [1:0]  st;
    logic [4:0]  pos;
    int          idx;
    req = d[3:0];
    val = d[35:4];
    tgt = d[67:36];
    st  = ST_OK;
    pos = '0;
    case (req)
      REQ_INS_FRONT, REQ_INS_END: begin
        if (list_len >= DEPTH) st = ST_FULL;
        else put_at(req == REQ_INS_FRONT ? 0 : list_len, val);
      end
      REQ_INS_BEFORE, REQ_INS_AFTER: begin
        if (list_len >= DEPTH) st = ST_FULL;
        else if (list_len == 0) st = ST_EMPTY;
        else begin
          idx = find_first(tgt);
          if (idx >= list_len) st = ST_NOTFOUND;
          else put_at(req == REQ_INS_BEFORE ? idx : idx + 1, val);
        end
      end
      REQ_DEL_FRONT, REQ_DEL_END: begin
        if (list_len == 0) st = ST_EMPTY;
        else take_at(req == REQ_DEL_FRONT ? 0 : list_len - 1);
      end
      REQ_DEL_VALUE: begin
        if (list_len == 0) st = ST_EMPTY;
        else begin
          idx = find_first(val);
          if (idx >= list_len) st = ST_NOTFOUND;
          else take_at(idx);
        end
      end
      REQ_SEARCH: begin
        idx = find_first(val);
        if (idx >= list_len) st = ST_NOTFOUND;
        else pos = 5'(idx + 1);
      end
      REQ_DUMP: begin
        if (list_len == 0) st = ST_EMPTY;
        else begin
          for (int i = 0; i < list_len; i++)
            result_q.push_back('{ST_OK, 5'd0, list_mem[i], i + 1 == list_len});
          return;
        end
      end
      default: ;
    endcase
    result_q.push_back('{st, pos, 32'd0, 1'b1});
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      list_len   = 0;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (in_tvalid && in_tready) predict_request(in_tdata);
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected: tdata=%h", out_tdata);
          fail_count = fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (out_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tdata[1:0]);
            fail_count = fail_count + 1;
          end
          if (out_tdata[6:2] !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, out_tdata[6:2]);
            fail_count = fail_count + 1;
          end
          if (out_tdata[38:7] !== want.element) begin
            $error("element: expected %0d, actual %0d", $signed(want.element),
                   $signed(out_tdata[38:7]));
            fail_count = fail_count + 1;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_tlast);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/testbench.sv
// Top of the ordered list engine testbench: clock, reset, request stimulus,
// receiver stalls and verdict. Depends on ole_pkg, ole_checker and the block.
`timescale 1ns / 1ps
module testbench;
  import ole_pkg::*;

  localparam int DEPTH = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  bit          long_hold = 1'b0;
  int          rx_wait = 0;
  logic [31:0] pool [8];

  ordered_list_engine_top #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  ole_checker #(.DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_request(logic [3:0] req, logic [31:0] val, logic [31:0] tgt);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, tgt, val, req};
    do @(posedge clk); while (!in_tready);
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return pool[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [3:0] pick_req(int fill_bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 4'($urandom_range(9, 15));
    if (r < 25 + fill_bias) return $urandom_range(0, 1) ? REQ_INS_FRONT : REQ_INS_END;
    if (r < 45 + fill_bias) return $urandom_range(0, 1) ? REQ_INS_BEFORE : REQ_INS_AFTER;
    if (r < 85) return 4'($urandom_range(4, 7));
    return REQ_DUMP;
  endfunction

  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else if (long_hold) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      n = $urandom_range(0, 12);
      if ($urandom_range(0, 2) == 0) n = 0;
      rx_wait <= n;
      out_tready <= (n == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(REQ_DUMP, 0, 0);
    send_request(REQ_DEL_FRONT, 0, 0);
    send_request(REQ_DEL_END, 0, 0);
    send_request(REQ_DEL_VALUE, pool[0], 0);
    send_request(REQ_SEARCH, pool[0], 0);
    send_request(REQ_INS_BEFORE, pool[0], pool[1]);
    send_request(REQ_INS_FRONT, 32'h8000_0000, 0);
    send_request(REQ_INS_END, 32'h7fff_ffff, 0);
    send_request(REQ_INS_AFTER, 32'hffff_ffff, 32'h8000_0000);
    send_request(REQ_INS_BEFORE, 32'd0, 32'h7fff_ffff);
    send_request(REQ_INS_AFTER, pool[2], pool[3]);
    send_request(REQ_SEARCH, 32'h7fff_ffff, 0);
    send_request(REQ_DEL_VALUE, pool[3], 0);
    send_request(4'd15, 32'hffff_ffff, 32'hffff_ffff);
    send_request(4'd9, 0, 0);
    send_request(REQ_DUMP, 0, 0);
    for (int i = 0; i < 13; i++) send_request(REQ_INS_END, pool[i % 8], 0);
    send_request(REQ_INS_FRONT, 1, 0);
    send_request(REQ_INS_AFTER, 1, pool[0]);
    send_request(REQ_SEARCH, pool[7], 0);
    send_request(REQ_DUMP, 0, 0);

    fork
      begin
        long_hold = 1'b1;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_request(pick_req(0), pick_value(), pick_value());
    join
    stop_input();
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < 400; i++) begin
      send_request(pick_req((i / 100) % 2 == 0 ? 15 : -10), pick_value(), pick_value());
      if (i % 50 == 49) begin
        stop_input();
        while (pending != 0) @(posedge clk);
      end
    end

    stop_input();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
